// ===== src/complementary_tilt_filter_unit_defines.svh =====
// Assertion macros for the complementary tilt filter.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef COMPLEMENTARY_TILT_FILTER_UNIT_DEFINES_SVH
`define COMPLEMENTARY_TILT_FILTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset
`define CTF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctf: same-cycle check failed");
// Next-cycle implication, sampled on clk, off during reset
`define CTF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctf: next-cycle check failed");
`else
`define CTF_ASSERT_IMP(label, ante, cons)
`define CTF_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== src/ctf_pkg.sv =====
// Shared types, widths and the arctangent table of the tilt filter.
// No dependencies; every other file but the assertion header refers to it by scoped names.
package ctf_pkg;

  localparam int IN_W    = 16;  // sample fields
  localparam int CFG_W   = 16;  // widest config register
  localparam int ANG_W   = 32;  // stored angle, 1/65536 degree
  localparam int CO_W    = 17;  // CORDIC operand before scaling
  localparam int CX_W    = 27;  // CORDIC x/y datapath
  localparam int CZ_W    = 26;  // CORDIC angle accumulator
  localparam int DLT_W   = 30;  // gyro increment
  localparam int DIFF_W  = 34;  // blend multiplicand
  localparam int ROOT_W  = 16;  // square root result
  localparam int TAB_LEN = 24;
  localparam int TAB_IW  = 5;

  localparam logic signed [CZ_W-1:0] DEG180_Q16 = 26'sd11796480;

  // Status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } ctf_stat_t;

  typedef struct packed {
    logic signed [IN_W-1:0] accel_x;
    logic signed [IN_W-1:0] accel_y;
    logic signed [IN_W-1:0] accel_z;
    logic signed [IN_W-1:0] rate_x;
    logic signed [IN_W-1:0] rate_y;
  } ctf_in_t;

  typedef struct packed {
    logic signed [IN_W-1:0] pitch_out;
    logic signed [IN_W-1:0] roll_out;
  } ctf_out_t;

  // atan(2^-i) in 1/65536 degree, rounded to nearest
  function automatic logic signed [CZ_W-1:0] atan_q16(input logic [TAB_IW-1:0] idx);
    logic signed [CZ_W-1:0] v;
    unique case (idx)
      5'd0:    v = 26'sd2949120;
      5'd1:    v = 26'sd1740967;
      5'd2:    v = 26'sd919879;
      5'd3:    v = 26'sd466945;
      5'd4:    v = 26'sd234379;
      5'd5:    v = 26'sd117304;
      5'd6:    v = 26'sd58666;
      5'd7:    v = 26'sd29335;
      5'd8:    v = 26'sd14668;
      5'd9:    v = 26'sd7334;
      5'd10:   v = 26'sd3667;
      5'd11:   v = 26'sd1833;
      5'd12:   v = 26'sd917;
      5'd13:   v = 26'sd458;
      5'd14:   v = 26'sd229;
      5'd15:   v = 26'sd115;
      5'd16:   v = 26'sd57;
      5'd17:   v = 26'sd29;
      5'd18:   v = 26'sd14;
      5'd19:   v = 26'sd7;
      5'd20:   v = 26'sd4;
      5'd21:   v = 26'sd2;
      5'd22:   v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/ctf_if.sv =====
// Valid/ready channel interfaces for the tilt filter samples and results.
// Depends on ctf_pkg for the payload structs.
interface ctf_in_if;
  logic             valid;
  logic             ready;
  ctf_pkg::ctf_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ctf_out_if;
  logic              valid;
  logic              ready;
  ctf_pkg::ctf_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/ctf_isqrt.sv =====
// Floor square root of a^2 + b^2, two radicand bits per cycle.
// Depends on ctf_pkg.
module ctf_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [ctf_pkg::IN_W-1:0] a_in,
  input  logic signed [ctf_pkg::IN_W-1:0] b_in,
  output ctf_pkg::ctf_stat_t            stat,
  output logic [ctf_pkg::ROOT_W-1:0]    root
);

  localparam int RW = ctf_pkg::ROOT_W;
  localparam logic [3:0] ROOT_LAST = 4'(RW - 1);

  typedef enum logic [1:0] {S_IDLE, S_SQB, S_ROOT} state_t;

  state_t              state_r;
  logic                done_r;
  logic [3:0]          cnt_r;
  logic signed [ctf_pkg::IN_W-1:0] b_r;
  logic [2*RW-1:0]     v_r;
  logic [RW:0]         rem_r;
  logic [RW-1:0]       root_r;

  logic signed [ctf_pkg::IN_W-1:0] sq_op;
  logic signed [2*RW-1:0] sq;
  logic [RW+2:0]       rem_sh;
  logic [RW+2:0]       trial;
  logic                ge;
  logic [RW:0]         rem_nxt;
  logic [RW-1:0]       root_nxt;

  // Square the first operand on start, the second in the cycle after
  assign sq_op = (state_r == S_IDLE) ? a_in : b_r;
  assign sq    = (2*RW)'(sq_op) * (2*RW)'(sq_op);

  // One root digit: bring down two bits, try (root << 2) | 1
  assign rem_sh   = {rem_r, v_r[2*RW-1 -: 2]};
  assign trial    = (RW+3)'({root_r, 2'b01});
  assign ge       = rem_sh >= trial;
  assign rem_nxt  = ge ? (RW+1)'(rem_sh - trial) : rem_sh[RW:0];
  assign root_nxt = {root_r[RW-2:0], ge};

  // Sequence: square, square and add, then one digit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_SQB;
          end
        end
        S_SQB: begin
          cnt_r   <= '0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == ROOT_LAST) begin
            state_r <= S_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      if (start) begin
        b_r <= b_in;
        v_r <= sq;
      end
    end else if (state_r == S_SQB) begin
      v_r    <= v_r + sq;
      rem_r  <= '0;
      root_r <= '0;
    end else begin
      v_r    <= {v_r[2*RW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

// ===== src/ctf_cordic.sv =====
// Vectoring CORDIC for atan2(y, x) in 1/65536 degree, one rotation per cycle.
// Depends on ctf_pkg for widths and the arctangent table.
module ctf_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [ctf_pkg::CO_W-1:0] y_in,
  input  logic signed [ctf_pkg::CO_W-1:0] x_in,
  output ctf_pkg::ctf_stat_t              stat,
  output logic signed [ctf_pkg::CZ_W-1:0] angle
);

  localparam int XW = ctf_pkg::CX_W;
  localparam int ZW = ctf_pkg::CZ_W;
  localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [SW-1:0] STEP_LAST = SW'(CORDIC_STEPS - 1);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t               state_r;
  logic                 done_r;
  logic [SW-1:0]        step_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic signed [ZW-1:0] z_r;

  logic                 zero_in;
  logic                 neg_in;
  logic signed [ctf_pkg::CO_W-1:0] xs;
  logic signed [ctf_pkg::CO_W-1:0] ys;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  logic signed [ZW-1:0] z0;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] tab;
  logic                 up;

  // Fold the left half-plane onto the right, then scale by 2^8
  assign zero_in = (x_in == '0) && (y_in == '0);
  assign neg_in  = x_in[ctf_pkg::CO_W-1];
  assign xs      = neg_in ? -x_in : x_in;
  assign ys      = neg_in ? -y_in : y_in;
  assign x0      = XW'(xs) <<< 8;
  assign y0      = XW'(ys) <<< 8;
  assign z0      = !neg_in ? '0
                 : (y_in[ctf_pkg::CO_W-1] ? -ctf_pkg::DEG180_Q16 : ctf_pkg::DEG180_Q16);

  // One micro-rotation; arithmetic shifts round toward minus infinity
  assign dx  = y_r >>> step_r;
  assign dy  = x_r >>> step_r;
  assign tab = ctf_pkg::atan_q16(ctf_pkg::TAB_IW'(step_r));
  assign up  = !y_r[XW-1];

  // Step counter; both operands zero give angle zero at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            step_r <= '0;
            if (zero_in) begin
              done_r <= 1'b1;
            end else begin
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          step_r <= step_r + SW'(1);
          if (step_r == STEP_LAST) begin
            state_r <= S_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Rotate toward the x axis
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      if (start) begin
        x_r <= x0;
        y_r <= y0;
        z_r <= z0;
      end
    end else if (up) begin
      x_r <= x_r + dx;
      y_r <= y_r - dy;
      z_r <= z_r + tab;
    end else begin
      x_r <= x_r - dx;
      y_r <= y_r + dy;
      z_r <= z_r - tab;
    end
  end

  assign stat.busy = (state_r == S_RUN);
  assign stat.done = done_r;
  assign angle     = z_r;

endmodule

// ===== src/ctf_gyro.sv =====
// Gyro increment rate * period / 10, rounded half away from zero.
// Bit-serial multiply then bit-serial divide by ten; depends on ctf_pkg.
module ctf_gyro (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [ctf_pkg::IN_W-1:0]  rate_in,
  input  logic [ctf_pkg::CFG_W-1:0]        period_in,
  output ctf_pkg::ctf_stat_t               stat,
  output logic signed [ctf_pkg::DLT_W-1:0] delta
);

  localparam int W  = ctf_pkg::IN_W;
  localparam int QW = ctf_pkg::DLT_W - 1;
  localparam logic [4:0]     MUL_LAST = 5'(W - 1);
  localparam logic [4:0]     DIV_LAST = 5'(2*W - 1);
  localparam logic [4:0]     TEN      = 5'd10;
  localparam logic [2*W-1:0] HALF_TEN = (2*W)'(5);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} state_t;

  state_t          state_r;
  logic            done_r;
  logic [4:0]      cnt_r;
  logic            neg_r;
  logic [W-1:0]    mcand_r;
  logic [W-1:0]    mplier_r;
  logic [W-1:0]    hi_r;
  logic [W-1:0]    lo_r;
  logic [2*W-1:0]  num_r;
  logic [3:0]      rem_r;
  logic [QW-1:0]   q_r;

  logic [W-1:0]    mag;
  logic [W:0]      sum;
  logic [2*W-1:0]  prod;
  logic [4:0]      t;
  logic            ge;
  logic signed [ctf_pkg::DLT_W-1:0] qs;

  assign mag = rate_in[W-1] ? (~$unsigned(rate_in) + W'(1)) : $unsigned(rate_in);

  // Multiply step: add the multiplicand on a set bit, shift right
  assign sum  = {1'b0, hi_r} + (mplier_r[0] ? {1'b0, mcand_r} : '0);
  assign prod = {sum, lo_r[W-1:1]};

  // Divide step: bring down one bit, subtract ten when it fits
  assign t  = {rem_r, num_r[2*W-1]};
  assign ge = t >= TEN;

  assign qs    = $signed({1'b0, q_r});
  assign delta = neg_r ? -qs : qs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cnt_r   <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == MUL_LAST) begin
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == DIV_LAST) begin
            state_r <= S_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          neg_r    <= rate_in[W-1];
          mcand_r  <= mag;
          mplier_r <= period_in;
          hi_r     <= '0;
          lo_r     <= '0;
        end
      end
      S_MUL: begin
        hi_r     <= sum[W:1];
        lo_r     <= {sum[0], lo_r[W-1:1]};
        mplier_r <= mplier_r >> 1;
        if (cnt_r == MUL_LAST) begin
          num_r <= prod + HALF_TEN;
          rem_r <= '0;
          q_r   <= '0;
        end
      end
      S_DIV: begin
        rem_r <= ge ? 4'(t - TEN) : t[3:0];
        q_r   <= {q_r[QW-2:0], ge};
        num_r <= {num_r[2*W-2:0], 1'b0};
      end
      default: begin
        hi_r <= hi_r;
      end
    endcase
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = done_r;

endmodule

// ===== src/ctf_blend.sv =====
// Blend of the integrated angle with the accelerometer angle by alpha,
// as acc + alpha * (angle + delta - acc) / 2^16; holds the stored angle.
module ctf_blend (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [ctf_pkg::DLT_W-1:0] delta_in,
  input  logic signed [ctf_pkg::CZ_W-1:0]  acc_in,
  input  logic [ctf_pkg::CFG_W-1:0]        alpha_in,
  output ctf_pkg::ctf_stat_t               stat,
  output logic signed [ctf_pkg::ANG_W-1:0] angle
);

  localparam int DW    = ctf_pkg::DIFF_W;
  localparam int SUM_W = DW + 1;
  localparam int RES_W = DW + 2;
  localparam int AW    = ctf_pkg::ANG_W;
  localparam int MW    = ctf_pkg::CFG_W;
  localparam logic [3:0] MUL_LAST = 4'(MW - 1);
  localparam logic signed [AW-1:0] ANG_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ANG_MIN = {1'b1, {(AW-1){1'b0}}};

  typedef enum logic {S_IDLE, S_MUL} state_t;

  state_t                           state_r;
  logic                             done_r;
  logic [3:0]                       cnt_r;
  logic signed [AW-1:0]             angle_r;
  logic signed [DW-1:0]             diff_r;
  logic signed [DW-1:0]             hi_r;
  logic [MW-1:0]                    mplier_r;
  logic signed [ctf_pkg::CZ_W-1:0]  acc_r;

  logic signed [DW-1:0]    diff0;
  logic signed [SUM_W-1:0] sum;
  logic signed [RES_W-1:0] res;
  logic                    fits;
  logic signed [AW-1:0]    res_sat;

  assign diff0 = DW'(angle_r) + DW'(delta_in) - DW'(acc_in);

  // Multiply step; the high part stays within the multiplicand's range
  assign sum = SUM_W'(hi_r) + (mplier_r[0] ? SUM_W'(diff_r) : '0);

  // Round half up: the last bit shifted out is bit 15 of the low product
  assign res = RES_W'(acc_r) + RES_W'($signed(sum[SUM_W-1:1]))
             + RES_W'({1'b0, sum[0]});
  assign fits = (res[RES_W-1:AW-1] == '0) || (res[RES_W-1:AW-1] == '1);
  assign res_sat = fits ? res[AW-1:0] : (res[RES_W-1] ? ANG_MIN : ANG_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
      angle_r <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cnt_r   <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == MUL_LAST) begin
            angle_r <= res_sat;
            state_r <= S_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      if (start) begin
        diff_r   <= diff0;
        hi_r     <= '0;
        mplier_r <= alpha_in;
        acc_r    <= acc_in;
      end
    end else begin
      hi_r     <= sum[SUM_W-1:1];
      mplier_r <= mplier_r >> 1;
    end
  end

  assign stat.busy = (state_r == S_MUL);
  assign stat.done = done_r;
  assign angle     = angle_r;

endmodule

// ===== src/complementary_tilt_filter_unit.sv =====
// Complementary tilt filter: one accelerometer/gyro sample in, one fused
// pitch/roll pair out in 1/128 degree. An accepted sample starts the
// bit-serial gyro multiply and divide by ten, the square root followed by the
// pitch CORDIC, and the roll CORDIC, all side by side; once every one of them
// is done the blend starts, its bit-serial multiply runs, and the result is
// loaded into the output register. The next sample is taken once the result
// sits in the output register, and a held result keeps the finished blend
// waiting for that load.
// Configuration: index 0 swap_axes, 1 alpha_q16, 2 period_q16. Depends on
// ctf_pkg, ctf_if and the unit modules.
`include "complementary_tilt_filter_unit_defines.svh"

module complementary_tilt_filter_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [ctf_pkg::CFG_W-1:0] cfg_data,
  ctf_in_if.sink                    in_s,
  ctf_out_if.source                 out_s
);

  localparam int W  = ctf_pkg::IN_W;
  localparam int AW = ctf_pkg::ANG_W;
  localparam int CO = ctf_pkg::CO_W;

  localparam logic [1:0] REG_SWAP   = 2'd0;
  localparam logic [1:0] REG_ALPHA  = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;
  localparam logic [ctf_pkg::CFG_W-1:0] ALPHA_RST  = 16'd64881;
  localparam logic [ctf_pkg::CFG_W-1:0] PERIOD_RST = 16'd655;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_BLEND} state_t;

  // Stored angle to output units: round half up by 2^9, saturate to 16 bits
  function automatic logic signed [W-1:0] to_out(input logic signed [AW-1:0] a);
    logic signed [AW:0] t;
    logic               ok;
    logic signed [W-1:0] v;
    t  = (AW+1)'(a) + (AW+1)'(256);
    ok = (t[AW:W+8] == '0) || (t[AW:W+8] == '1);
    v  = ok ? t[W+8:9] : (t[AW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
    return v;
  endfunction

  state_t                   state_r;
  logic                     sqd_r;
  logic                     out_valid_r;
  logic                     swap_r;
  logic [ctf_pkg::CFG_W-1:0] alpha_r;
  logic [ctf_pkg::CFG_W-1:0] period_r;
  logic signed [W-1:0]      ax_r;
  ctf_pkg::ctf_out_t        out_r;

  logic                     accept;
  logic                     front_busy;
  logic                     blend_go;
  logic                     out_load;
  logic signed [W-1:0]      ax, ay, gx, gy;
  logic signed [CO-1:0]     p_y, p_x, r_y, r_x;

  ctf_pkg::ctf_stat_t       sq_stat, cp_stat, cr_stat, gp_stat, gr_stat, bp_stat, br_stat;
  logic [ctf_pkg::ROOT_W-1:0] root;
  logic signed [ctf_pkg::CZ_W-1:0]  pitch_grav, roll_grav;
  logic signed [ctf_pkg::DLT_W-1:0] pitch_dlt, roll_dlt;
  logic signed [AW-1:0]     pitch_ang, roll_ang;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r   <= 1'b0;
      alpha_r  <= ALPHA_RST;
      period_r <= PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SWAP:   swap_r   <= cfg_data[0];
        REG_ALPHA:  alpha_r  <= cfg_data;
        REG_PERIOD: period_r <= cfg_data;
        default:    swap_r   <= swap_r;
      endcase
    end
  end

  // Axis swap on the incoming transaction
  assign ax = swap_r ? in_s.data.accel_y : in_s.data.accel_x;
  assign ay = swap_r ? in_s.data.accel_x : in_s.data.accel_y;
  assign gx = swap_r ? in_s.data.rate_y  : in_s.data.rate_x;
  assign gy = swap_r ? in_s.data.rate_x  : in_s.data.rate_y;

  assign in_s.ready = (state_r == S_IDLE);
  assign accept     = in_s.valid && in_s.ready;

  // CORDIC operands: roll = atan2(ay, az), pitch = atan2(-ax, r)
  assign r_y = CO'(ay);
  assign r_x = CO'(in_s.data.accel_z);
  assign p_y = -CO'(ax_r);
  assign p_x = CO'({1'b0, root});

  always_ff @(posedge clk) begin
    if (accept) begin
      ax_r <= ax;
    end
  end

  ctf_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .a_in  (ay),
    .b_in  (in_s.data.accel_z),
    .stat  (sq_stat),
    .root  (root)
  );

  ctf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_pitch (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_stat.done),
    .y_in  (p_y),
    .x_in  (p_x),
    .stat  (cp_stat),
    .angle (pitch_grav)
  );

  ctf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_roll (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .y_in  (r_y),
    .x_in  (r_x),
    .stat  (cr_stat),
    .angle (roll_grav)
  );

  ctf_gyro u_gyro_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .rate_in   (gy),
    .period_in (period_r),
    .stat      (gp_stat),
    .delta     (pitch_dlt)
  );

  ctf_gyro u_gyro_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .rate_in   (gx),
    .period_in (period_r),
    .stat      (gr_stat),
    .delta     (roll_dlt)
  );

  ctf_blend u_blend_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (blend_go),
    .delta_in (pitch_dlt),
    .acc_in   (pitch_grav),
    .alpha_in (alpha_r),
    .stat     (bp_stat),
    .angle    (pitch_ang)
  );

  ctf_blend u_blend_roll (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (blend_go),
    .delta_in (roll_dlt),
    .acc_in   (roll_grav),
    .alpha_in (alpha_r),
    .stat     (br_stat),
    .angle    (roll_ang)
  );

  assign front_busy = sq_stat.busy || cp_stat.busy || cr_stat.busy
                   || gp_stat.busy || gr_stat.busy;
  assign blend_go   = (state_r == S_RUN) && sqd_r && !front_busy;
  assign out_load   = (state_r == S_BLEND) && !bp_stat.busy && !br_stat.busy
                   && (!out_valid_r || out_s.ready);

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sqd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          sqd_r <= 1'b0;
          if (accept) begin
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (sq_stat.done) begin
            sqd_r <= 1'b1;
          end
          if (blend_go) begin
            state_r <= S_BLEND;
          end
        end
        S_BLEND: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.pitch_out <= to_out(pitch_ang);
      out_r.roll_out  <= to_out(roll_ang);
    end
  end

  assign out_s.valid = out_valid_r;
  assign out_s.data  = out_r;

  // The root finishes once per transaction, while the front end runs
  `CTF_ASSERT_IMP(a_sq_done_in_run, sq_stat.done, (state_r == S_RUN) && !sqd_r)
  // Blending only starts after every front-end unit has settled
  `CTF_ASSERT_IMP(a_blend_front_idle, state_r == S_BLEND, !front_busy)
  // An accepted transaction always starts the root and the gyro units
  `CTF_ASSERT_NXT(a_accept_starts, accept,
                  (state_r == S_RUN) && sq_stat.busy && gp_stat.busy && gr_stat.busy)

endmodule
